### rtl/cpe_pkg.sv
// Shared types, codes and helpers for the conic profile evaluator.
package cpe_pkg;

	localparam int NUM_REGS = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_XX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_XY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONST = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDIV = 2'd1;
	localparam logic [1:0] ST_NEGD = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	// wide values: 63-bit signed, magnitude at most 2^62 - 1
	localparam logic [61:0] WIDE_MAX = 62'h3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] WIDE_MAX_S = 64'sh3FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic zdiv;
		logic negd;
		logic sat;
	} flag_t;

	typedef struct packed {
		flag_t                   flags;
		logic signed [62:0]      base;
		logic signed [62:0]      den;
	} sq_side_t;

	typedef struct packed {
		logic        sat;
		logic [61:0] m;
	} mres_t;

	typedef struct packed {
		logic               sat;
		logic signed [62:0] v;
	} sres_t;

	function automatic logic [61:0] wide_mag(input logic signed [62:0] v);
		logic [62:0] t;
		t = v[62] ? 63'(-v) : 63'(v);
		return t[61:0];
	endfunction

endpackage

### rtl/cpe_sqrt.sv
// Pipelined integer square root of a wide value scaled by the fraction bits.
module cpe_sqrt
	import cpe_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_vld,
	input  logic [61:0]                 in_rad,
	input  sq_side_t                    in_side,
	output logic                        out_vld,
	output logic [(63+FRAC_BITS)/2-1:0] out_root,
	output sq_side_t                    out_side
);

	localparam int SW  = (63 + FRAC_BITS) / 2;
	localparam int RMW = SW + 3;

	logic              vld_s  [SW+1];
	logic [RMW-1:0]    rem_s  [SW+1];
	logic [SW-1:0]     root_s [SW+1];
	logic [2*SW-1:0]   rad_s  [SW+1];
	sq_side_t          side_s [SW+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = (2*SW)'({in_rad, {FRAC_BITS{1'b0}}});
	assign side_s[0] = in_side;

	// one root bit per stage: bring down two radicand bits, try root*4+1
	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic [RMW-1:0] cur;
		logic [RMW-1:0] trial;
		logic [RMW-1:0] diff;
		logic           take;

		always_comb begin
			cur   = {rem_s[k][RMW-3:0], rad_s[k][2*SW-1 -: 2]};
			trial = RMW'({root_s[k], 2'b01});
			diff  = cur - trial;
			take  = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (advance) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k+1]  <= take ? diff : cur;
				root_s[k+1] <= {root_s[k][SW-2:0], take};
				rad_s[k+1]  <= rad_s[k] << 2;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[SW];
	assign out_root = root_s[SW];
	assign out_side = side_s[SW];

endmodule

### rtl/cpe_div.sv
// Pipelined fixed-point divider, one quotient bit per stage.
module cpe_div
	import cpe_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               in_vld,
	input  logic signed [62:0] in_num,
	input  logic signed [62:0] in_den,
	input  flag_t              in_flags,
	output logic               out_vld,
	output logic [32:0]        out_quot,
	output logic               out_neg,
	output flag_t              out_flags
);

	localparam int QB = 32;
	localparam int TW = 62 + FRAC_BITS;
	localparam int CW = 62 + QB;

	logic [61:0]  un;
	logic [61:0]  uq;
	logic [TW-1:0] th;
	logic          big;

	always_comb begin
		un  = wide_mag(in_num);
		uq  = wide_mag(in_den);
		th  = {un, {FRAC_BITS{1'b0}}};
		big = ({uq, {QB{1'b0}}} <= CW'(th));
	end

	logic          vld_s  [QB+1];
	logic [61:0]   rem_s  [QB+1];
	logic [QB-1:0] low_s  [QB+1];
	logic [QB-1:0] quo_s  [QB+1];
	logic [61:0]   den_s  [QB+1];
	logic          big_s  [QB+1];
	logic          neg_s  [QB+1];
	flag_t         flg_s  [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= in_vld;
		end
	end

	// quotient below 2^32 unless big, so the top part already sits below the divisor
	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s[0] <= 62'(th[TW-1:QB]);
			low_s[0] <= th[QB-1:0];
			quo_s[0] <= '0;
			den_s[0] <= uq;
			big_s[0] <= big;
			neg_s[0] <= in_num[62] ^ in_den[62];
			flg_s[0] <= in_flags;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [62:0] cur;
		logic [62:0] diff;
		logic        take;

		always_comb begin
			cur  = {rem_s[k], low_s[k][QB-1]};
			diff = cur - {1'b0, den_s[k]};
			take = (cur >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (advance) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k+1] <= take ? diff[61:0] : cur[61:0];
				low_s[k+1] <= low_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][QB-2:0], take};
				den_s[k+1] <= den_s[k];
				big_s[k+1] <= big_s[k];
				neg_s[k+1] <= neg_s[k];
				flg_s[k+1] <= flg_s[k];
			end
		end
	end

	assign out_vld   = vld_s[QB];
	assign out_quot  = big_s[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, quo_s[QB]};
	assign out_neg   = neg_s[QB];
	assign out_flags = flg_s[QB];

endmodule

### rtl/conic_profile_evaluator.sv
// Throughput: one sample beat per cycle while no result beat is held; the pipeline is the
// numbered arithmetic stages, one stage per root bit in the square root, the numerator stage,
// one setup and one stage per quotient bit in the divider, and the result register.
// A stalled result freezes the whole pipeline; sample_stall follows it in the same cycle.
// Reset clears the six coefficients to zero and all stage valid bits.
module conic_profile_evaluator
	import cpe_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic signed [31:0]   x_value,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [31:0]   y_value,
	output logic [1:0]           status
);

	localparam int XW = 64 - FRAC_BITS;
	localparam int GW = XW + 1;
	localparam int SW = (63 + FRAC_BITS) / 2;

	function automatic logic signed [62:0] signed_mag(input logic neg, input logic [61:0] m);
		logic signed [62:0] v;
		v = $signed({1'b0, m});
		return neg ? -v : v;
	endfunction

	function automatic mres_t sat_shift(input logic [127:0] p);
		logic [127:0] t;
		mres_t        r;
		t     = p >> FRAC_BITS;
		r.sat = |t[127:62];
		r.m   = r.sat ? WIDE_MAX : t[61:0];
		return r;
	endfunction

	function automatic sres_t clamp_add(input logic signed [62:0] a, input logic signed [62:0] b);
		logic signed [63:0] s;
		sres_t              r;
		s = {a[62], a} + {b[62], b};
		r.sat = 1'b0;
		if (s > WIDE_MAX_S) begin
			r.sat = 1'b1;
			r.v   = $signed({1'b0, WIDE_MAX});
		end else if (s < -WIDE_MAX_S) begin
			r.sat = 1'b1;
			r.v   = -$signed({1'b0, WIDE_MAX});
		end else begin
			r.v = s[62:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? -v : v;
	endfunction

	function automatic logic signed [62:0] sext32(input logic [31:0] v);
		return $signed({{31{v[31]}}, v});
	endfunction

	// coefficient registers
	logic [31:0] coef_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_XX:    coef_q[0] <= cfg_data;
				REG_YY:    coef_q[1] <= cfg_data;
				REG_XY:    coef_q[2] <= cfg_data;
				REG_X:     coef_q[3] <= cfg_data;
				REG_Y:     coef_q[4] <= cfg_data;
				REG_CONST: coef_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] ca, cb, cc, cd, ce, cf;
	assign ca = coef_q[0];
	assign cb = coef_q[1];
	assign cc = coef_q[2];
	assign cd = coef_q[3];
	assign ce = coef_q[4];
	assign cf = coef_q[5];

	logic out_vld_q;
	logic adv;

	assign adv          = !out_vld_q || !result_stall;
	assign sample_stall = !adv;

	// stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic sq_vld, dv_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= sq_vld;
			out_vld_q <= dv_vld;
		end
	end

	// stage 1: x*x, D*x, C*x on magnitudes
	logic [31:0] xm;
	logic [63:0] pxx_s1, pdx_s1, pcx_s1;
	logic        ndx_s1, ncx_s1;

	assign xm = mag32(x_value);

	always_ff @(posedge clk) begin
		if (adv) begin
			pxx_s1 <= xm * xm;
			pdx_s1 <= mag32(cd) * xm;
			pcx_s1 <= mag32(cc) * xm;
			ndx_s1 <= cd[31] ^ x_value[31];
			ncx_s1 <= cc[31] ^ x_value[31];
		end
	end

	// stage 2: scale, F + D x, C x + E
	logic [XW-1:0]      x2_s2;
	logic signed [62:0] h1_s2, g_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x2_s2 <= pxx_s1[63:FRAC_BITS];
			h1_s2 <= sext32(cf) + signed_mag(ndx_s1, 62'(pdx_s1[63:FRAC_BITS]));
			g_s2  <= signed_mag(ncx_s1, 62'(pcx_s1[63:FRAC_BITS])) + sext32(ce);
		end
	end

	// stage 3: partial products of A*x2 and g*g
	logic [61:0]            gm;
	logic [63:0]            pal_s3;
	logic [XW-1:0]          pah_s3;
	logic [63:0]            gll_s3;
	logic [GW-1:0]          glh_s3;
	logic [2*(GW-32)-1:0]   ghh_s3;
	logic signed [62:0]     h1_s3, g_s3;

	assign gm = wide_mag(g_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			pal_s3 <= mag32(ca) * x2_s2[31:0];
			pah_s3 <= mag32(ca) * x2_s2[XW-1:32];
			gll_s3 <= gm[31:0] * gm[31:0];
			glh_s3 <= gm[31:0] * gm[GW-1:32];
			ghh_s3 <= gm[GW-1:32] * gm[GW-1:32];
			h1_s3  <= h1_s2;
			g_s3   <= g_s2;
		end
	end

	// stage 4: combine partials, scale and saturate
	mres_t              ax2_r, gg_r;
	logic signed [62:0] ax2_s4, h1_s4, g_s4;
	logic [61:0]        gg_s4;
	logic               satl_s4, satq_s4;

	always_comb begin
		ax2_r = sat_shift(128'(pal_s3) + (128'(pah_s3) << 32));
		gg_r  = sat_shift(128'(gll_s3) + (128'(glh_s3) << 33) + (128'(ghh_s3) << 64));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax2_s4  <= signed_mag(ca[31], ax2_r.m);
			satl_s4 <= ax2_r.sat;
			gg_s4   <= gg_r.m;
			satq_s4 <= gg_r.sat;
			h1_s4   <= h1_s3;
			g_s4    <= g_s3;
		end
	end

	// stage 5: h = F + D x + A x^2
	sres_t              h_r;
	logic signed [62:0] h_s5, g_s5;
	logic [61:0]        gg_s5;
	logic               satl_s5, satq_s5;

	assign h_r = clamp_add(h1_s4, ax2_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s5    <= h_r.v;
			satl_s5 <= satl_s4 | h_r.sat;
			satq_s5 <= satq_s4;
			gg_s5   <= gg_s4;
			g_s5    <= g_s4;
		end
	end

	// stage 6: partial products of B*h
	logic [61:0]        hm;
	logic [63:0]        bhl_s6;
	logic [61:0]        bhh_s6;
	logic               nbh_s6;
	logic signed [62:0] h_s6, g_s6;
	logic [61:0]        gg_s6;
	logic               satl_s6, satq_s6;

	assign hm = wide_mag(h_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			bhl_s6  <= mag32(cb) * hm[31:0];
			bhh_s6  <= mag32(cb) * hm[61:32];
			nbh_s6  <= cb[31] ^ h_s5[62];
			h_s6    <= h_s5;
			g_s6    <= g_s5;
			gg_s6   <= gg_s5;
			satl_s6 <= satl_s5;
			satq_s6 <= satq_s5;
		end
	end

	// stage 7: 4 B h, scale and saturate
	mres_t              b4h_r;
	logic signed [62:0] b4h_s7, h_s7, g_s7;
	logic [61:0]        gg_s7;
	logic               satl_s7, satq_s7;

	assign b4h_r = sat_shift((128'(bhl_s6) + (128'(bhh_s6) << 32)) << 2);

	always_ff @(posedge clk) begin
		if (adv) begin
			b4h_s7  <= signed_mag(nbh_s6, b4h_r.m);
			satq_s7 <= satq_s6 | b4h_r.sat;
			satl_s7 <= satl_s6;
			h_s7    <= h_s6;
			g_s7    <= g_s6;
			gg_s7   <= gg_s6;
		end
	end

	// stage 8: discriminant and case selection
	sres_t       disc_r;
	logic        lin;
	logic [61:0] rad_s8;
	sq_side_t    side_s8;

	assign disc_r = clamp_add($signed({1'b0, gg_s7}), -b4h_s7);
	assign lin    = (cb == '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8.flags.zdiv <= lin && (g_s7 == '0);
			side_s8.flags.negd <= !lin && disc_r.v[62];
			side_s8.flags.sat  <= lin ? satl_s7 : (satl_s7 | satq_s7 | disc_r.sat);
			side_s8.base       <= lin ? -h_s7 : -g_s7;
			side_s8.den        <= lin ? g_s7 : $signed({{30{cb[31]}}, cb, 1'b0});
			// linear case takes a root of zero so the numerator stays -h
			rad_s8             <= (lin || disc_r.v[62]) ? '0 : disc_r.v[61:0];
		end
	end

	logic [SW-1:0] sq_root;
	sq_side_t      sq_side;

	cpe_sqrt #(
		.FRAC_BITS(FRAC_BITS)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv),
		.in_vld   (vld_s8),
		.in_rad   (rad_s8),
		.in_side  (side_s8),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// stage 9: numerator
	sres_t              num_r;
	logic signed [62:0] num_s9, den_s9;
	flag_t              flg_s9;

	assign num_r = clamp_add(sq_side.base, $signed(63'(sq_root)));

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s9         <= num_r.v;
			den_s9         <= sq_side.den;
			flg_s9.zdiv    <= sq_side.flags.zdiv;
			flg_s9.negd    <= sq_side.flags.negd;
			flg_s9.sat     <= sq_side.flags.sat | num_r.sat;
		end
	end

	logic [32:0] dv_quot;
	logic        dv_neg;
	flag_t       dv_flags;

	cpe_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (adv),
		.in_vld    (vld_s9),
		.in_num    (num_s9),
		.in_den    (den_s9),
		.in_flags  (flg_s9),
		.out_vld   (dv_vld),
		.out_quot  (dv_quot),
		.out_neg   (dv_neg),
		.out_flags (dv_flags)
	);

	// result register: sign, clamp to 32 bits, status
	logic        ovf;
	logic [32:0] qneg;
	logic [31:0] yv;
	logic [1:0]  st;
	logic [31:0] y_q;
	logic [1:0]  status_q;

	always_comb begin
		if (dv_neg) begin
			ovf  = dv_quot > 33'h0_8000_0000;
			qneg = -(ovf ? 33'h0_8000_0000 : dv_quot);
			yv   = qneg[31:0];
		end else begin
			ovf  = dv_quot > 33'h0_7FFF_FFFF;
			qneg = '0;
			yv   = ovf ? 32'h7FFF_FFFF : dv_quot[31:0];
		end
		if (dv_flags.zdiv) begin
			st = ST_ZDIV;
			yv = '0;
		end else if (dv_flags.negd) begin
			st = ST_NEGD;
			yv = '0;
		end else if (dv_flags.sat || ovf) begin
			st = ST_SAT;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_q      <= yv;
			status_q <= st;
		end
	end

	assign result_valid = out_vld_q;
	assign y_value      = $signed(y_q);
	assign status       = status_q;

endmodule

### rtl/cpe_check.sv
// Port-level checks for the conic profile evaluator, bound to the top level.
module cpe_check
	import cpe_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sample_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic signed [31:0]   y_value,
	input logic [1:0]           status
);

	// error results carry a zero ordinate
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_ZDIV || status == ST_NEGD) |-> y_value == '0)
		else $error("error status with nonzero y_value");

	// the sample side backs up exactly when a result beat is held
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall == (result_valid && result_stall))
		else $error("sample_stall does not follow the held result");

	// a held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(y_value) && $stable(status))
		else $error("held result beat changed");

endmodule

bind conic_profile_evaluator cpe_check u_check (.*);
